/* hw/rtl/vilu_pkg.sv */
`default_nettype none
package vilu_pkg;

    localparam int NREGS        = 32;
    localparam int LANES_DEF    = 4;
    localparam int Q_DEPTH      = 2;

    localparam logic [1:0] REQ_VV    = 2'd0;
    localparam logic [1:0] REQ_VI    = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;
    localparam logic [1:0] REQ_STORE = 2'd3;

    localparam logic [5:0] OP_ADD    = 6'h00;
    localparam logic [5:0] OP_SUB    = 6'h02;
    localparam logic [5:0] OP_AND    = 6'h09;
    localparam logic [5:0] OP_OR     = 6'h0A;
    localparam logic [5:0] OP_XOR    = 6'h0B;
    localparam logic [5:0] OP_GATHER = 6'h0C;
    localparam logic [5:0] OP_MERGE  = 6'h17;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNIMPL   = 2'd1;
    localparam logic [1:0] ST_MISALIGN = 2'd2;

    localparam logic [2:0] CFG_ALIGN_OFF = 3'd0;

    typedef enum logic [2:0] {
        K_OP, K_MERGE, K_LOAD, K_STORE, K_FAIL
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_STORE, S_ONE
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  op;
        logic [4:0]  vd;
        logic [4:0]  vs1;
        logic [4:0]  vs2;
        logic [3:0]  lane;
        logic [31:0] data;
        logic [1:0]  status;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [3:0]  lane;
        logic [31:0] value;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

/* hw/rtl/vector_integer_lane_unit_top.sv */
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+---------------------------
// request   | i_req_type .. i_lane_data                 | start & !busy
// result    | o_status o_out_lane o_out_value o_last    | o_strobe, one cycle, no stall
// config    | psel penable pwrite paddr pwdata prdata   | apb, pready tied high
//
// vv op: 2*LANES source reads through the single ram read port, then one lane written
// and emitted per cycle; merge and store emit one beat per lane; a queued load or error
// gives one beat. a two-entry queue sits between decode and execution. after reset a
// clearing sweep zeroes all 32*LANES words of the file, busy held high. results cannot
// be stalled; otherwise busy rises only while the queue is full.
`default_nettype none
module vector_integer_lane_unit_top #(
    parameter int LANES = vilu_pkg::LANES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [5:0]  i_funct6,
    input  wire logic [4:0]  i_dest_reg,
    input  wire logic [4:0]  i_src1_reg,
    input  wire logic [4:0]  i_src2_reg,
    input  wire logic [4:0]  i_immediate,
    input  wire logic [31:0] i_mem_addr,
    input  wire logic [3:0]  i_lane_index,
    input  wire logic [31:0] i_lane_data,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [3:0]       o_out_lane,
    output logic [31:0]      o_out_value,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import vilu_pkg::*;

    logic    r_align_off;
    logic    q_valid, q_pop, clearing;
    t_cmd    q_cmd;
    t_result res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_ALIGN_OFF[2]) ? {31'd0, r_align_off} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align_off <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == CFG_ALIGN_OFF[2]) begin
            r_align_off <= pwdata[0];
        end
    end

    vilu_front #(.LANES(LANES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_hold       (clearing),
        .i_align_off  (r_align_off),
        .i_req_type   (i_req_type),
        .i_funct6     (i_funct6),
        .i_dest_reg   (i_dest_reg),
        .i_src1_reg   (i_src1_reg),
        .i_src2_reg   (i_src2_reg),
        .i_immediate  (i_immediate),
        .i_mem_addr   (i_mem_addr),
        .i_lane_index (i_lane_index),
        .i_lane_data  (i_lane_data),
        .o_busy       (busy),
        .o_q_valid    (q_valid),
        .o_q_cmd      (q_cmd),
        .i_q_pop      (q_pop)
    );

    vilu_back #(.LANES(LANES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_res      (res)
    );

    assign o_strobe    = res.valid;
    assign o_status    = res.status;
    assign o_out_lane  = res.lane;
    assign o_out_value = res.value;
    assign o_last      = res.last;
endmodule
`default_nettype wire

/* hw/rtl/vilu_ram.sv */
`default_nettype none
module vilu_ram #(
    parameter int W = 32,
    parameter int D = 128
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/vilu_front.sv */
`default_nettype none
module vilu_front #(
    parameter int LANES = vilu_pkg::LANES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_hold,
    input  wire logic          i_align_off,
    input  wire logic [1:0]    i_req_type,
    input  wire logic [5:0]    i_funct6,
    input  wire logic [4:0]    i_dest_reg,
    input  wire logic [4:0]    i_src1_reg,
    input  wire logic [4:0]    i_src2_reg,
    input  wire logic [4:0]    i_immediate,
    input  wire logic [31:0]   i_mem_addr,
    input  wire logic [3:0]    i_lane_index,
    input  wire logic [31:0]   i_lane_data,
    output logic               o_busy,
    output logic               o_q_valid,
    output vilu_pkg::t_cmd     o_q_cmd,
    input  wire logic          i_q_pop
);
    import vilu_pkg::*;

    localparam int QPW = $clog2(Q_DEPTH);

    t_cmd           r_q [Q_DEPTH];
    logic [QPW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [QPW:0]   r_cnt, n_cnt;
    t_cmd           cmd;
    logic           keep;
    logic           push;

    always_comb begin
        cmd        = '0;
        cmd.op     = i_funct6;
        cmd.vd     = i_dest_reg;
        cmd.vs1    = i_src1_reg;
        cmd.vs2    = i_src2_reg;
        cmd.lane   = i_lane_index;
        cmd.data   = i_lane_data;
        cmd.status = ST_OK;
        cmd.kind   = K_FAIL;
        keep       = 1'b1;
        unique case (i_req_type)
            REQ_VV: begin
                case (i_funct6) inside
                    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_GATHER: cmd.kind = K_OP;
                    default: cmd.status = ST_UNIMPL;
                endcase
            end
            REQ_VI: begin
                if (i_funct6 == OP_MERGE && i_src2_reg == 5'd0) begin
                    cmd.kind = K_MERGE;
                    cmd.data = {{27{i_immediate[4]}}, i_immediate};
                end else begin
                    cmd.status = ST_UNIMPL;
                end
            end
            default: begin
                if (!i_align_off && i_mem_addr[1:0] != 2'd0) begin
                    cmd.status = ST_MISALIGN;
                end else if (i_req_type == REQ_LOAD) begin
                    cmd.kind = K_LOAD;
                    // lane beyond the register: nothing written, no beat
                    keep = (32'(i_lane_index) < 32'(LANES));
                end else begin
                    cmd.kind = K_STORE;
                end
            end
        endcase
    end

    assign o_busy    = i_hold || (r_cnt == (QPW+1)'(Q_DEPTH));
    assign push      = i_start && !o_busy && keep;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_q[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == QPW'(Q_DEPTH-1)) ? '0 : r_wr + 1'b1;
        end
        if (i_q_pop && o_q_valid) begin
            n_rd = (r_rd == QPW'(Q_DEPTH-1)) ? '0 : r_rd + 1'b1;
        end
        n_cnt = r_cnt + (QPW+1)'(push) - (QPW+1)'(i_q_pop && o_q_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wr] <= cmd;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/vilu_back.sv */
`default_nettype none
module vilu_back #(
    parameter int LANES = vilu_pkg::LANES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire vilu_pkg::t_cmd i_q_cmd,
    output logic                o_q_pop,
    output logic                o_clearing,
    output vilu_pkg::t_result   o_res
);
    import vilu_pkg::*;

    localparam int DEPTH = NREGS * LANES;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(LANES);
    localparam int CW    = $clog2(2*LANES+1);

    t_state         r_state, n_state;
    t_cmd           r_cmd, n_cmd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [AW-1:0]  r_clr, n_clr;
    logic [31:0]    r_a [LANES];
    logic [31:0]    r_b [LANES];
    t_result        r_res, n_res;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [31:0]    wdata, rdata;
    logic           cap;
    logic [CW-1:0]  cap_idx;
    logic [31:0]    a_v, b_v, g_v, x_v;

    function automatic logic [AW-1:0] loc(input logic [4:0] r, input logic [LW-1:0] l);
        loc = AW'(r) * AW'(LANES) + AW'(l);
    endfunction

    vilu_ram #(.W(32), .D(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign a_v = r_a[r_cnt[LW-1:0]];
    assign b_v = r_b[r_cnt[LW-1:0]];
    assign g_v = (a_v >= 32'(LANES)) ? 32'd0 : r_b[a_v[LW-1:0]];

    always_comb begin
        case (r_cmd.op)
            OP_ADD:    x_v = a_v + b_v;
            OP_SUB:    x_v = b_v - a_v;
            OP_AND:    x_v = a_v & b_v;
            OP_OR:     x_v = a_v | b_v;
            OP_XOR:    x_v = a_v ^ b_v;
            OP_GATHER: x_v = g_v;
            default:   x_v = '0;
        endcase
        if (r_cmd.kind == K_MERGE) begin
            x_v = r_cmd.data;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_cnt   = r_cnt;
        n_clr   = r_clr;
        n_res   = '0;
        o_q_pop = 1'b0;
        we      = 1'b0;
        waddr   = '0;
        wdata   = '0;
        raddr   = '0;
        cap     = 1'b0;
        cap_idx = r_cnt - 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH-1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_cnt = '0;
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    unique case (i_q_cmd.kind)
                        K_OP:    n_state = S_READ;
                        K_MERGE: n_state = S_EXEC;
                        K_STORE: n_state = S_STORE;
                        default: n_state = S_ONE;
                    endcase
                end
            end
            S_READ: begin
                // vs1 lanes then vs2 lanes, read data arrives in the cycle after its address
                if (r_cnt < CW'(LANES)) begin
                    raddr = loc(r_cmd.vs1, r_cnt[LW-1:0]);
                end else begin
                    raddr = loc(r_cmd.vs2, LW'(r_cnt - CW'(LANES)));
                end
                cap   = (r_cnt != '0);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(2*LANES)) begin
                    n_cnt   = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                we          = 1'b1;
                waddr       = loc(r_cmd.vd, r_cnt[LW-1:0]);
                wdata       = x_v;
                n_res.valid = 1'b1;
                n_res.lane  = 4'(r_cnt);
                n_res.value = x_v;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CW'(LANES-1)) begin
                    n_res.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_STORE: begin
                raddr = loc(r_cmd.vd, r_cnt[LW-1:0]);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt != '0) begin
                    n_res.valid = 1'b1;
                    n_res.lane  = 4'(cap_idx);
                    n_res.value = rdata;
                end
                if (r_cnt == CW'(LANES)) begin
                    n_res.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_ONE: begin
                n_res.valid  = 1'b1;
                n_res.last   = 1'b1;
                n_res.status = r_cmd.status;
                if (r_cmd.kind == K_LOAD) begin
                    we          = 1'b1;
                    waddr       = loc(r_cmd.vd, r_cmd.lane[LW-1:0]);
                    wdata       = r_cmd.data;
                    n_res.lane  = r_cmd.lane;
                    n_res.value = r_cmd.data;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cnt     <= '0;
            r_res     <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_cnt     <= n_cnt;
            r_res     <= n_res;
        end
        r_cmd <= n_cmd;
        if (cap) begin
            if (cap_idx < CW'(LANES)) begin
                r_a[cap_idx[LW-1:0]] <= rdata;
            end else begin
                r_b[LW'(cap_idx - CW'(LANES))] <= rdata;
            end
        end
    end

    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !r_res.valid)
        else $error("beat during clearing sweep");
    a_exec_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> r_res.valid)
        else $error("lane write without a beat");
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res.valid && r_res.status != ST_OK) |-> r_res.last)
        else $error("error beat not final");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE && i_q_valid))
        else $error("queue popped while working");
endmodule
`default_nettype wire
